>>> rtl/core/dhcp_request_responder_macros.svh
// ----------------------------------------------------------------------------
// DHCP request responder assertion macros
// Shared property wrappers for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef DHCP_REQUEST_RESPONDER_MACROS_SVH
`define DHCP_REQUEST_RESPONDER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define DRR_ASSERT_HOLD(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define DRR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/drr_pkg.sv
// ----------------------------------------------------------------------------
// drr_pkg
// Types and constants shared by the DHCP request responder modules.
// ----------------------------------------------------------------------------
package drr_pkg;

  localparam int OPT_START = 240;
  localparam logic [7:0] OPT_PAD      = 8'd0;
  localparam logic [7:0] OPT_MSG_TYPE = 8'd53;
  localparam logic [7:0] OPT_END      = 8'd255;
  localparam logic [7:0] TYPE_DISCOVER = 8'd1;
  localparam logic [7:0] TYPE_REQUEST  = 8'd3;

  localparam logic REPLY_OFFER = 1'b0;
  localparam logic REPLY_ACK   = 1'b1;

  localparam logic [31:0] ADDR_RESET = 32'hC0A8_0402;

  localparam int QDEPTH = 4;
  localparam int QAW    = 2;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2,
    PH_TYPE = 2'd3
  } walk_phase_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_word_t;

  typedef struct packed {
    logic        reply_kind;
    logic [31:0] transaction_id;
    logic [47:0] client_mac;
    logic [31:0] reply_address;
  } out_word_t;

  // descriptor handed from parser to reply stage
  typedef struct packed {
    logic        reply_kind;
    logic [31:0] transaction_id;
    logic [47:0] client_mac;
  } desc_t;

endpackage

>>> rtl/core/drr_parser.sv
// ----------------------------------------------------------------------------
// drr_parser
// Front end: counts packet bytes, captures xid and MAC, walks the options
// and emits one descriptor per Discover or Request packet.
// ----------------------------------------------------------------------------
module drr_parser
  import drr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     acc,
  input  in_word_t word,
  output logic     desc_push,
  output desc_t    desc
);

  localparam int PW = $clog2(MAX_PACKET_BYTES + 1);
  localparam int NW = $clog2(MAX_PACKET_BYTES + 257);

  logic [PW-1:0] pos_r, pos_nxt, pos_upd;
  logic [31:0]   xid_r, xid_nxt, xid_upd;
  logic [47:0]   mac_r, mac_nxt, mac_upd;
  logic [NW-1:0] nos_r, nos_nxt, nos_upd;
  walk_phase_t   phase_r, phase_nxt, phase_upd;
  logic [7:0]    type_r, type_nxt, type_upd;
  logic          done_r, done_nxt, done_upd;

  logic [7:0]    b;
  logic          in_range, walk_en, at_nos, take;
  logic [NW-1:0] pos_x;

  assign b        = word.data_byte;
  assign in_range = acc && (pos_r < PW'(MAX_PACKET_BYTES));
  assign walk_en  = in_range && !done_r && (pos_r >= PW'(OPT_START));
  assign pos_x    = NW'(pos_r);
  assign at_nos   = (pos_x == nos_r);
  assign take     = walk_en && (phase_r == PH_CODE || (phase_r == PH_BODY && at_nos));

  // next walk phase
  always_comb begin
    phase_upd = phase_r;
    if (take) begin
      if (b == OPT_PAD) phase_upd = PH_BODY;
      else if (b == OPT_MSG_TYPE) phase_upd = PH_TYPE;
      else if (b != OPT_END) phase_upd = PH_LEN;
    end else if (walk_en && phase_r == PH_LEN) begin
      phase_upd = PH_BODY;
    end
    phase_nxt = (acc && word.last_byte) ? PH_CODE : phase_upd;
  end

  // walk outputs and captures
  always_comb begin
    nos_upd  = nos_r;
    done_upd = done_r;
    type_upd = type_r;
    if (take) begin
      if (b == OPT_PAD) nos_upd = pos_x + NW'(1);
      else if (b == OPT_MSG_TYPE) nos_upd = pos_x + NW'(2);
      else if (b == OPT_END) done_upd = 1'b1;
    end else if (walk_en && phase_r == PH_LEN) begin
      nos_upd = pos_x + NW'(1) + NW'(b);
    end else if (walk_en && phase_r == PH_TYPE && at_nos) begin
      type_upd = b;
      done_upd = 1'b1;
    end

    xid_upd = xid_r;
    mac_upd = mac_r;
    pos_upd = pos_r;
    if (in_range) begin
      if (pos_r >= PW'(4) && pos_r <= PW'(7)) xid_upd = {xid_r[23:0], b};
      if (pos_r >= PW'(28) && pos_r <= PW'(33)) mac_upd = {mac_r[39:0], b};
      pos_upd = pos_r + PW'(1);
    end

    if (acc && word.last_byte) begin
      pos_nxt  = '0;
      xid_nxt  = '0;
      mac_nxt  = '0;
      nos_nxt  = NW'(OPT_START);
      done_nxt = 1'b0;
      type_nxt = '0;
    end else begin
      pos_nxt  = pos_upd;
      xid_nxt  = xid_upd;
      mac_nxt  = mac_upd;
      nos_nxt  = nos_upd;
      done_nxt = done_upd;
      type_nxt = type_upd;
    end

    desc_push = acc && word.last_byte && (pos_upd >= PW'(OPT_START)) &&
                (type_upd == TYPE_DISCOVER || type_upd == TYPE_REQUEST);
    desc.reply_kind     = (type_upd == TYPE_REQUEST) ? REPLY_ACK : REPLY_OFFER;
    desc.transaction_id = xid_upd;
    desc.client_mac     = mac_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      xid_r   <= '0;
      mac_r   <= '0;
      nos_r   <= NW'(OPT_START);
      phase_r <= PH_CODE;
      type_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      xid_r   <= xid_nxt;
      mac_r   <= mac_nxt;
      nos_r   <= nos_nxt;
      phase_r <= phase_nxt;
      type_r  <= type_nxt;
      done_r  <= done_nxt;
    end
  end

endmodule

>>> rtl/core/drr_queue.sv
// ----------------------------------------------------------------------------
// drr_queue
// Small descriptor queue between the parser and the reply stage.
// ----------------------------------------------------------------------------
module drr_queue
  import drr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  desc_t push_desc,
  input  logic  pop,
  output desc_t head,
  output logic  empty,
  output logic  full
);

  desc_t          slot_r [QDEPTH];
  logic [QAW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QAW:0]   cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign empty   = (cnt_r == '0);
  assign full    = (cnt_r == (QAW+1)'(QDEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + QAW'(1) : wp_r;
    rp_nxt  = do_pop ? rp_r + QAW'(1) : rp_r;
    cnt_nxt = cnt_r + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wp_r] <= push_desc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

>>> rtl/core/drr_reply.sv
// ----------------------------------------------------------------------------
// drr_reply
// Back end: holds the offered address and loads queued descriptors into
// the result register.
// ----------------------------------------------------------------------------
module drr_reply
  import drr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data,
  input  desc_t       head,
  input  logic        q_empty,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output out_word_t   out_word
);

  logic [31:0] addr_r, addr_nxt;
  logic        ov_r, ov_nxt;
  out_word_t   ow_r, ow_nxt;

  assign cfg_ready = 1'b1;
  assign q_pop     = !q_empty && (!ov_r || out_pop);
  assign out_empty = !ov_r;
  assign out_word  = ow_r;

  always_comb begin
    addr_nxt = (cfg_valid && cfg_ready) ? cfg_data : addr_r;
    ov_nxt   = q_pop || (ov_r && !out_pop);
    ow_nxt   = ow_r;
    if (q_pop) begin
      ow_nxt.reply_kind     = head.reply_kind;
      ow_nxt.transaction_id = head.transaction_id;
      ow_nxt.client_mac     = head.client_mac;
      ow_nxt.reply_address  = addr_r;
    end
  end

  always_ff @(posedge clk) begin
    ow_r <= ow_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= ADDR_RESET;
      ov_r   <= 1'b0;
    end else begin
      addr_r <= addr_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule

>>> rtl/core/dhcp_request_responder.sv
// ----------------------------------------------------------------------------
// dhcp_request_responder
// Parses DHCP client packets byte by byte and queues offer/ack descriptors.
//
//   channel  ports                       handshake
//   in       in_word / in_push, in_full  push && !full
//   out      out_word / out_pop, out_empty  pop && !empty
//   cfg      cfg_data / cfg_valid, cfg_ready  valid && ready
//
// One byte per cycle while in_full is low; the parser updates its counter
// and walk state in the cycle a byte is taken. A result passes through the
// queue, then the result register, on its way to out_word after its last
// byte. in_full rises only when four descriptors are queued behind an unread
// result. Synchronous reset, no clearing pass.
// ----------------------------------------------------------------------------
module dhcp_request_responder
  import drr_pkg::*;
#(
  parameter int MAX_PACKET_BYTES = 2048
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  in_word_t    in_word,
  output logic        out_empty,
  input  logic        out_pop,
  output out_word_t   out_word,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic  acc, desc_push, q_empty, q_full, q_pop;
  desc_t desc, head;

  assign in_full = q_full;
  assign acc     = in_push && !q_full;

  drr_parser #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .word      (in_word),
    .desc_push (desc_push),
    .desc      (desc)
  );

  drr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_desc (desc),
    .pop       (q_pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  drr_reply u_reply (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .head      (head),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

endmodule

>>> rtl/core/drr_checker.sv
// ----------------------------------------------------------------------------
// drr_checker
// Port-level checks for the DHCP request responder, bound to the top level.
// ----------------------------------------------------------------------------
`include "dhcp_request_responder_macros.svh"

module drr_checker
  import drr_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_push,
  input logic      in_full,
  input logic      out_empty,
  input logic      out_pop,
  input out_word_t out_word
);

  // a waiting result holds until taken
  `DRR_ASSERT_NEXT(a_out_hold, clk, rst_n, !out_empty && !out_pop, !out_empty && $stable(out_word))
  // queue can only be full with a result already on the ports
  `DRR_ASSERT_HOLD(a_full_has_out, clk, rst_n, in_full, !out_empty)
  // full clears only after a result word was taken
  `DRR_ASSERT_HOLD(a_full_release, clk, rst_n, $past(rst_n) && $fell(in_full), $past(out_pop && !out_empty))

endmodule

bind dhcp_request_responder drr_checker u_drr_checker (.*);

>>> tb/sv/tb_dhcp_request_responder.sv
// ----------------------------------------------------------------------------
// tb_dhcp_request_responder
// Self-checking bench for the DHCP request responder. Whole client packets
// are built byte by byte (directed table of packet shapes, then random
// packets), pushed with random gaps, and every descriptor popped is compared
// against a local option-walk parser or a typed reply. One long receiver stall
// fills the descriptor queue. The offered address changes only between phases.
// ----------------------------------------------------------------------------
module tb_dhcp_request_responder;
  import drr_pkg::*;

  localparam int MAX_BYTES     = 2048;
  localparam int HOLD_CYCLES   = 2600;
  localparam int SETTLE_CYCLES = 8;
  localparam int LIMIT_CYCLES  = 600000;

  typedef enum {
    SH_SINGLE, SH_SHORT, SH_BARE, SH_PLAIN, SH_PADDED, SH_AFTER_OPTS,
    SH_END_FIRST, SH_NO53, SH_TRUNC_CODE, SH_TRUNC_LEN, SH_PAST_END,
    SH_HIDDEN, SH_OVER_LATE, SH_OVER_EDGE, SH_OVER_EARLY
  } shape_e;

  // how a packet's outcome is checked: parser, typed "no reply", typed reply
  typedef enum {CHK_MODEL, CHK_QUIET, CHK_REPLY} chk_e;

  typedef struct {
    shape_e      shape;
    logic [7:0]  mtype;
    logic [31:0] xid;
    logic [47:0] mac;
    chk_e        chk;
    logic        kind;
  } plan_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  in_word_t    in_word   = '0;
  logic        out_pop   = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [31:0] cfg_data  = '0;
  logic        in_full;
  logic        out_empty;
  out_word_t   out_word;
  logic        cfg_ready;

  dhcp_request_responder #(.MAX_PACKET_BYTES(MAX_BYTES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  int cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb_dhcp_request_responder: done, errors");
      $finish;
    end
  end

  int          errors = 0;
  int          replies_predicted = 0;
  out_word_t   replies_due[$];
  logic [7:0]  pkt[$];
  bit          calm = 1'b0;
  bit          hold_req = 1'b0;

  // ---- parser shadow ----
  logic [31:0]  offered_addr = ADDR_RESET;
  int           p_pos;
  logic [31:0]  p_xid;
  logic [47:0]  p_mac;
  int           p_next;
  walk_phase_t  p_phase;
  logic [7:0]   p_type;
  bit           p_done;

  function automatic void restart_walk();
    p_pos   = 0;
    p_xid   = '0;
    p_mac   = '0;
    p_next  = OPT_START;
    p_phase = PH_CODE;
    p_type  = '0;
    p_done  = 1'b0;
  endfunction

  function automatic void take_option(int pos, logic [7:0] b);
    if (b == OPT_PAD) begin
      p_next  = pos + 1;
      p_phase = PH_BODY;
    end else if (b == OPT_END) begin
      p_done = 1'b1;
    end else if (b == OPT_MSG_TYPE) begin
      // type value sits two bytes on, whatever the length byte says
      p_next  = pos + 2;
      p_phase = PH_TYPE;
    end else begin
      p_phase = PH_LEN;
    end
  endfunction

  function automatic void parse_byte(in_word_t w, output bit hit, output out_word_t r);
    hit = 1'b0;
    r   = '0;
    if (p_pos < MAX_BYTES) begin
      if (p_pos >= 4 && p_pos <= 7)   p_xid = {p_xid[23:0], w.data_byte};
      if (p_pos >= 28 && p_pos <= 33) p_mac = {p_mac[39:0], w.data_byte};
      if (!p_done && p_pos >= OPT_START) begin
        case (p_phase)
          PH_CODE: take_option(p_pos, w.data_byte);
          PH_LEN: begin
            p_next  = p_pos + 1 + int'(w.data_byte);
            p_phase = PH_BODY;
          end
          PH_BODY: if (p_pos == p_next) take_option(p_pos, w.data_byte);
          default: if (p_pos == p_next) begin
            p_type = w.data_byte;
            p_done = 1'b1;
          end
        endcase
      end
      p_pos++;
    end
    if (w.last_byte) begin
      if (p_pos >= OPT_START && (p_type == TYPE_DISCOVER || p_type == TYPE_REQUEST)) begin
        hit              = 1'b1;
        r.reply_kind     = (p_type == TYPE_REQUEST) ? REPLY_ACK : REPLY_OFFER;
        r.transaction_id = p_xid;
        r.client_mac     = p_mac;
        r.reply_address  = offered_addr;
      end
      restart_walk();
    end
  endfunction

  // ---- packet builder ----
  function automatic void add_type(logic [7:0] mtype);
    pkt.push_back(OPT_MSG_TYPE);
    pkt.push_back(($urandom_range(0, 99) < 80) ? 8'd1 : 8'($urandom()));
    pkt.push_back(mtype);
  endfunction

  function automatic void add_fill();
    int n;
    int len;
    logic [7:0] code;
    n = $urandom_range(0, 4);
    repeat (n) begin
      if ($urandom_range(0, 99) < 30) begin
        pkt.push_back(OPT_PAD);
      end else begin
        code = 8'($urandom_range(1, 254));
        if (code == OPT_MSG_TYPE) code = code + 8'd1;
        len = $urandom_range(0, 6);
        pkt.push_back(code);
        pkt.push_back(8'(len));
        repeat (len) pkt.push_back(8'($urandom()));
      end
    end
  endfunction

  function automatic void build_packet(shape_e sh, logic [7:0] mtype, logic [31:0] xid,
                                       logic [47:0] mac);
    int n;
    int i;
    logic [7:0] b;
    pkt.delete();
    n = (sh == SH_SHORT) ? $urandom_range(2, OPT_START - 1) : (sh == SH_SINGLE) ? 1 : OPT_START;
    for (i = 0; i < n; i++) begin
      b = 8'($urandom());
      if (i >= 4 && i <= 7)   b = xid[(7 - i) * 8 +: 8];
      if (i >= 28 && i <= 33) b = mac[(33 - i) * 8 +: 8];
      pkt.push_back(b);
    end
    case (sh)
      SH_PLAIN:      add_type(mtype);
      SH_PADDED: begin
        repeat ($urandom_range(1, 6)) pkt.push_back(OPT_PAD);
        add_type(mtype);
      end
      SH_AFTER_OPTS: begin
        add_fill();
        add_type(mtype);
      end
      SH_END_FIRST: begin
        add_fill();
        pkt.push_back(OPT_END);
        add_type(mtype);
      end
      SH_NO53: begin
        add_fill();
        pkt.push_back(OPT_END);
      end
      SH_TRUNC_CODE: begin
        add_fill();
        pkt.push_back(OPT_MSG_TYPE);
      end
      SH_TRUNC_LEN: begin
        add_fill();
        pkt.push_back(OPT_MSG_TYPE);
        pkt.push_back(8'd1);
      end
      SH_PAST_END: begin
        add_fill();
        pkt.push_back(8'd61);
        pkt.push_back(8'd200);
        add_type(mtype);
      end
      SH_HIDDEN: begin
        // type option buried in another option's body
        pkt.push_back(8'd43);
        pkt.push_back(8'd3);
        add_type(mtype);
        pkt.push_back(OPT_END);
      end
      SH_OVER_LATE: begin
        while (pkt.size() < MAX_BYTES - 2) pkt.push_back(OPT_PAD);
        add_type(mtype);
      end
      SH_OVER_EDGE: begin
        while (pkt.size() < MAX_BYTES - 3) pkt.push_back(OPT_PAD);
        add_type(mtype);
      end
      SH_OVER_EARLY: begin
        add_type(mtype);
        pkt.push_back(OPT_END);
      end
      default: ;
    endcase
    if (sh == SH_OVER_LATE || sh == SH_OVER_EDGE || sh == SH_OVER_EARLY) begin
      n = MAX_BYTES + $urandom_range(1, 16);
      while (pkt.size() < n) pkt.push_back(8'($urandom()));
    end else if (sh != SH_SHORT && sh != SH_SINGLE && sh != SH_BARE &&
                 sh != SH_TRUNC_CODE && sh != SH_TRUNC_LEN) begin
      repeat ($urandom_range(0, 3)) pkt.push_back(8'($urandom()));
    end
  endfunction

  // ---- sender side ----
  task automatic send_byte(in_word_t w);
    while (!calm && $urandom_range(0, 99) < 37) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_full);
  endtask

  task automatic send_packet(chk_e chk, out_word_t fixed);
    in_word_t  w;
    bit        hit;
    out_word_t r;
    int        i;
    for (i = 0; i < pkt.size(); i++) begin
      w.data_byte = pkt[i];
      w.last_byte = (i == pkt.size() - 1);
      parse_byte(w, hit, r);
      if (w.last_byte) begin
        if (chk == CHK_REPLY) begin
          replies_due.push_back(fixed);
        end else if (chk == CHK_MODEL && hit) begin
          replies_due.push_back(r);
          replies_predicted++;
        end
      end
      send_byte(w);
    end
  endtask

  task automatic send_random_packet();
    shape_e      sh;
    logic [7:0]  mtype;
    int          u;
    u = $urandom_range(0, 99);
    if      (u < 60) sh = shape_e'(SH_PLAIN + $urandom_range(0, 2));
    else if (u < 66) sh = SH_SHORT;
    else if (u < 70) sh = SH_BARE;
    else if (u < 74) sh = SH_END_FIRST;
    else if (u < 78) sh = SH_NO53;
    else if (u < 82) sh = SH_TRUNC_CODE;
    else if (u < 85) sh = SH_TRUNC_LEN;
    else if (u < 89) sh = SH_PAST_END;
    else if (u < 93) sh = SH_HIDDEN;
    else if (u < 95) sh = SH_SINGLE;
    else if (u < 97) sh = SH_OVER_EARLY;
    else if (u < 98) sh = SH_OVER_EDGE;
    else             sh = SH_OVER_LATE;
    u = $urandom_range(0, 99);
    mtype = (u < 45) ? TYPE_DISCOVER : (u < 90) ? TYPE_REQUEST : 8'($urandom());
    build_packet(sh, mtype, $urandom(), {16'($urandom()), $urandom()});
    send_packet(CHK_MODEL, '0);
  endtask

  // drop push, let every descriptor drain, then let the parser settle
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_address(logic [31:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    offered_addr = v;
  endtask

  // ---- receiver side ----
  int hold_left = 0;
  bit hold_done = 1'b0;

  task automatic check_reply(out_word_t got);
    out_word_t want;
    if (replies_due.size() == 0) begin
      $error("unexpected reply word: %h", got);
      errors++;
    end else begin
      want = replies_due.pop_front();
      if (got.reply_kind !== want.reply_kind) begin
        $error("reply_kind: expected %0d, got %0d", want.reply_kind, got.reply_kind);
        errors++;
      end
      if (got.transaction_id !== want.transaction_id) begin
        $error("transaction_id: expected %h, got %h", want.transaction_id,
               got.transaction_id);
        errors++;
      end
      if (got.client_mac !== want.client_mac) begin
        $error("client_mac: expected %h, got %h", want.client_mac, got.client_mac);
        errors++;
      end
      if (got.reply_address !== want.reply_address) begin
        $error("reply_address: expected %h, got %h", want.reply_address,
               got.reply_address);
        errors++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) check_reply(out_word);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= calm || ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // ---- stimulus ----
  plan_row_t plan [19] = '{
    '{SH_SINGLE,     TYPE_DISCOVER, 32'h0,         48'h0,            CHK_QUIET, REPLY_OFFER},
    '{SH_SHORT,      TYPE_DISCOVER, 32'h0102_0304, 48'h0a0b_0c0d_0e0f, CHK_QUIET, REPLY_OFFER},
    '{SH_BARE,       TYPE_DISCOVER, 32'h5555_aaaa, 48'haaaa_5555_aaaa, CHK_QUIET, REPLY_OFFER},
    '{SH_PLAIN,      TYPE_DISCOVER, 32'h0,         48'h0,            CHK_REPLY, REPLY_OFFER},
    '{SH_PLAIN,      TYPE_REQUEST,  32'hffff_ffff, 48'hffff_ffff_ffff, CHK_REPLY, REPLY_ACK},
    '{SH_PLAIN,      8'd2,          32'h1111_2222, 48'h3333_4444_5555, CHK_QUIET, REPLY_OFFER},
    '{SH_PLAIN,      8'd0,          32'h89ab_cdef, 48'h0123_4567_89ab, CHK_QUIET, REPLY_OFFER},
    '{SH_PLAIN,      8'd255,        32'h7fff_ffff, 48'h8000_0000_0001, CHK_QUIET, REPLY_OFFER},
    '{SH_PADDED,     TYPE_DISCOVER, 32'h1234_5678, 48'h0012_3456_789a, CHK_MODEL, REPLY_OFFER},
    '{SH_AFTER_OPTS, TYPE_REQUEST,  32'hdead_beef, 48'hfedc_ba98_7654, CHK_MODEL, REPLY_ACK},
    '{SH_END_FIRST,  TYPE_DISCOVER, 32'h0bad_cafe, 48'h00aa_bbcc_ddee, CHK_QUIET, REPLY_OFFER},
    '{SH_NO53,       TYPE_REQUEST,  32'h600d_f00d, 48'h1122_3344_5566, CHK_QUIET, REPLY_ACK},
    '{SH_TRUNC_CODE, TYPE_DISCOVER, 32'h0000_0001, 48'h0000_0000_0001, CHK_QUIET, REPLY_OFFER},
    '{SH_TRUNC_LEN,  TYPE_REQUEST,  32'h8000_0000, 48'h8000_0000_0000, CHK_QUIET, REPLY_ACK},
    '{SH_PAST_END,   TYPE_DISCOVER, 32'h4242_4242, 48'h2424_2424_2424, CHK_QUIET, REPLY_OFFER},
    '{SH_HIDDEN,     TYPE_REQUEST,  32'h1357_9bdf, 48'h2468_ace0_1357, CHK_QUIET, REPLY_ACK},
    '{SH_OVER_LATE,  TYPE_DISCOVER, 32'hcafe_0001, 48'hbeef_0000_0001, CHK_QUIET, REPLY_OFFER},
    '{SH_OVER_EDGE,  TYPE_REQUEST,  32'hcafe_0002, 48'hbeef_0000_0002, CHK_MODEL, REPLY_ACK},
    '{SH_OVER_EARLY, TYPE_DISCOVER, 32'hcafe_0003, 48'hbeef_0000_0003, CHK_MODEL, REPLY_OFFER}
  };

  initial begin
    out_word_t fixed;
    int        ph;
    int        k;
    restart_walk();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed packets run on the reset address
    foreach (plan[i]) begin
      build_packet(plan[i].shape, plan[i].mtype, plan[i].xid, plan[i].mac);
      fixed = '{reply_kind: plan[i].kind, transaction_id: plan[i].xid,
                client_mac: plan[i].mac, reply_address: ADDR_RESET};
      send_packet(plan[i].chk, fixed);
    end

    // receiver stalls while back-to-back replies pile up and block the input
    write_address(32'h0);
    hold_req = 1'b1;
    calm = 1'b1;
    repeat (8) begin
      build_packet(SH_PLAIN, ($urandom_range(0, 1) != 0) ? TYPE_REQUEST : TYPE_DISCOVER,
                   $urandom(), {16'($urandom()), $urandom()});
      send_packet(CHK_MODEL, '0);
    end
    calm = 1'b0;

    for (ph = 0; ph < 4 || replies_predicted < 56; ph++) begin
      write_address((ph == 0) ? 32'hffff_ffff : $urandom());
      for (k = 0; k < 14; k++) begin
        calm = (ph == 1 && k < 6);
        send_random_packet();
      end
      calm = 1'b0;
    end

    wait_drained();
    errors += replies_due.size();
    if (errors == 0)
      $display("tb_dhcp_request_responder: done, clean");
    else
      $display("tb_dhcp_request_responder: done, errors");
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/drr_pkg.sv
rtl/core/drr_parser.sv
rtl/core/drr_queue.sv
rtl/core/drr_reply.sv
rtl/core/dhcp_request_responder.sv
rtl/core/drr_checker.sv
tb/sv/tb_dhcp_request_responder.sv
